// ===== design/assert_macros.svh =====
// Assertion helpers for the completion ring unit.
// Macros expect clk and arst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCCR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCCR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mccr_pkg.sv =====
// Shared constants, codes and control bundles for the completion ring unit.
// No dependencies.
`default_nettype none

package mccr_pkg;

	localparam int CONTEXTS_DEF   = 64;
	localparam int RING_DEPTH_DEF = 16;
	localparam int MIN_RING_DEF   = 8;
	localparam int MAX_RESULTS    = 16;

	localparam int OP_W   = 3;
	localparam int REQ_W  = 6;
	localparam int RREQ_W = 32;
	localparam int ME_W   = 16;
	localparam int WORD_W = 64;
	localparam int ST_W   = 2;
	localparam int DCNT_W = 5;

	localparam int SCAN_LANES = 8;

	localparam logic [OP_W-1:0] OP_SETUP   = 3'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd2;
	localparam logic [OP_W-1:0] OP_CANCEL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DRAIN   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_CTX  = 2'd2;

	typedef struct packed {
		logic scan_start;
		logic set;
		logic clear;
	} live_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} live_sts_t;

endpackage

`default_nettype wire

// ===== design/mccr_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; used for the context table and the event store.
`default_nettype none

module mccr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/mccr_live_table.sv =====
// Live flags of all context slots and the lowest-free-slot scanner.
// Depends on mccr_pkg.
`default_nettype none

module mccr_live_table #(
	parameter int CONTEXTS = mccr_pkg::CONTEXTS_DEF,
	parameter int CTX_W    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mccr_pkg::live_ctl_t ctl,
	input  wire logic [CTX_W-1:0]    wr_idx,
	input  wire logic [CTX_W-1:0]    rd_idx,
	output logic                     rd_live,
	output mccr_pkg::live_sts_t      sts,
	output logic [CTX_W-1:0]         slot
);

	localparam int LANES  = mccr_pkg::SCAN_LANES;
	localparam int LANE_W = $clog2(LANES);
	localparam int CHUNKS = (CONTEXTS + LANES - 1) / LANES;
	localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	logic [CONTEXTS-1:0]     live_q;
	logic                    scanning_q;
	logic [CH_W-1:0]         chunk_q;
	logic [CHUNKS*LANES-1:0] free_pad;
	logic [LANES-1:0]        lane_free;
	logic [LANE_W-1:0]       lane;
	logic                    any_free;
	logic                    last_chunk;

	assign rd_live = live_q[rd_idx];

	// padding slots past the table never count as free
	always_comb begin
		free_pad = '0;
		free_pad[CONTEXTS-1:0] = ~live_q;
	end

	assign lane_free  = free_pad[chunk_q*LANES +: LANES];
	assign last_chunk = (chunk_q == CH_W'(CHUNKS - 1));

	always_comb begin
		any_free = 1'b0;
		lane     = '0;
		for (int j = LANES - 1; j >= 0; j--) begin
			if (lane_free[j]) begin
				any_free = 1'b1;
				lane     = LANE_W'(j);
			end
		end
	end

	assign sts.done  = scanning_q && (any_free || last_chunk);
	assign sts.found = scanning_q && any_free;
	assign slot      = CTX_W'({chunk_q, lane});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			scanning_q <= 1'b0;
			chunk_q    <= '0;
		end else begin
			if (ctl.scan_start) begin
				scanning_q <= 1'b1;
				chunk_q    <= '0;
			end else if (scanning_q) begin
				if (sts.done) begin
					scanning_q <= 1'b0;
				end else begin
					chunk_q <= chunk_q + CH_W'(1);
				end
			end
			if (ctl.set) begin
				live_q[wr_idx] <= 1'b1;
			end else if (ctl.clear) begin
				live_q[wr_idx] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/multi_context_completion_rings_unit.sv =====
// Top level of the completion ring unit: command sequencer, context table RAM,
// event store RAM and output register. Depends on mccr_pkg, mccr_ram,
// mccr_live_table and assert_macros.svh.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid, in_ready | opcode, context_req, ring_request, max_events,
//          |                    | user_data, request_tag, outcome
//  output  | out_valid,         | status, context_out, has_event, event_data,
//          | out_ready          | event_tag, event_outcome, drained_count, last
//
// One command is in flight at a time; in_ready is high only while the
// sequencer is idle. Destroy, cancel and rejected commands go from idle to
// the response; push and empty drains first read the ring state, setup runs
// the free slot scan (eight slots a cycle), and a drain reads the ring state,
// then per event does one event store read and one output load.
// Output stalls hold the sequencer in place.
// Reset clears the live flags at once; no RAM needs a clearing pass, since a
// context's ring state is only read after setup has written it.
`default_nettype none

`include "assert_macros.svh"

module multi_context_completion_rings_unit #(
	parameter int CONTEXTS   = mccr_pkg::CONTEXTS_DEF,
	parameter int RING_DEPTH = mccr_pkg::RING_DEPTH_DEF,
	parameter int MIN_RING   = mccr_pkg::MIN_RING_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic        [mccr_pkg::OP_W-1:0]     opcode,
	input  wire logic        [mccr_pkg::REQ_W-1:0]    context_req,
	input  wire logic        [mccr_pkg::RREQ_W-1:0]   ring_request,
	input  wire logic signed [mccr_pkg::ME_W-1:0]     max_events,
	input  wire logic        [mccr_pkg::WORD_W-1:0]   user_data,
	input  wire logic        [mccr_pkg::WORD_W-1:0]   request_tag,
	input  wire logic signed [mccr_pkg::WORD_W-1:0]   outcome,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic             [mccr_pkg::ST_W-1:0]     status,
	output logic             [mccr_pkg::REQ_W-1:0]    context_out,
	output logic                                      has_event,
	output logic             [mccr_pkg::WORD_W-1:0]   event_data,
	output logic             [mccr_pkg::WORD_W-1:0]   event_tag,
	output logic signed      [mccr_pkg::WORD_W-1:0]   event_outcome,
	output logic             [mccr_pkg::DCNT_W-1:0]   drained_count,
	output logic                                      last
);

	localparam int CTX_W    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int PTR_W    = $clog2(RING_DEPTH);
	localparam int CNT_W    = $clog2(RING_DEPTH + 1);
	localparam int EV_DEPTH = CONTEXTS * RING_DEPTH;
	localparam int EV_AW    = $clog2(EV_DEPTH);
	localparam int WORD_W   = mccr_pkg::WORD_W;
	localparam int EV_W     = 3 * WORD_W;
	localparam int ME_W     = mccr_pkg::ME_W;
	localparam int DCNT_W   = mccr_pkg::DCNT_W;
	localparam int ST_W     = mccr_pkg::ST_W;
	localparam int REQ_W    = mccr_pkg::REQ_W;

	// per-context ring state, one RAM word per slot
	typedef struct packed {
		logic [CNT_W-1:0] size;
		logic [PTR_W-1:0] rp;
		logic [PTR_W-1:0] wp;
		logic [CNT_W-1:0] count;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_META = 6'b000100,
		S_DRD  = 6'b001000,
		S_DOUT = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// latched command
	logic [mccr_pkg::OP_W-1:0]   op_q;
	logic [CTX_W-1:0]            ctx_q;
	logic [mccr_pkg::RREQ_W-1:0] ring_request_q;
	logic [ME_W-1:0]             max_events_q;
	logic [EV_W-1:0]             event_word_q;

	// single-result response
	logic [ST_W-1:0]  resp_status_q, resp_status_d;
	logic [REQ_W-1:0] resp_ctx_q, resp_ctx_d;

	// drain working copy of the ring state
	logic [CNT_W-1:0]  size_q;
	logic [PTR_W-1:0]  rp_q;
	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DCNT_W-1:0] want_q;
	logic [DCNT_W-1:0] done_q;

	// output register
	logic              out_valid_q;
	logic              out_load;
	logic [ST_W-1:0]   status_q;
	logic [REQ_W-1:0]  context_out_q;
	logic              has_event_q;
	logic [EV_W-1:0]   event_word_out_q;
	logic [DCNT_W-1:0] drained_count_q;
	logic              last_q;

	// RAM ports
	logic              meta_we, meta_re;
	logic [CTX_W-1:0]  meta_waddr;
	meta_t             meta_wdata, meta_rdata;
	logic              ev_we, ev_re;
	logic [EV_AW-1:0]  ev_waddr, ev_raddr;
	logic [EV_W-1:0]   ev_rdata;

	// live table
	mccr_pkg::live_ctl_t live_ctl;
	mccr_pkg::live_sts_t live_sts;
	logic [CTX_W-1:0]    live_wr_idx;
	logic [CTX_W-1:0]    scan_slot;
	logic                rd_live;

	logic              accept;
	logic              out_free;
	logic [CTX_W-1:0]  in_ctx;
	logic              ctx_ok;
	logic              last_event;
	logic [CNT_W-1:0]  setup_size;
	meta_t             push_meta;
	logic [DCNT_W-1:0] drain_want;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] size);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= size) ? '0 : PTR_W'(n);
	endfunction

	function automatic logic [EV_AW-1:0] ev_addr(input logic [CTX_W-1:0] c,
			input logic [PTR_W-1:0] p);
		return EV_AW'(c) * EV_AW'(RING_DEPTH) + EV_AW'(p);
	endfunction

	mccr_ram #(
		.DEPTH(CONTEXTS),
		.WIDTH(META_W)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (in_ctx),
		.rdata (meta_rdata)
	);

	mccr_ram #(
		.DEPTH(EV_DEPTH),
		.WIDTH(EV_W)
	) u_event_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (event_word_q),
		.re    (ev_re),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	mccr_live_table #(
		.CONTEXTS(CONTEXTS),
		.CTX_W   (CTX_W)
	) u_live (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (live_ctl),
		.wr_idx  (live_wr_idx),
		.rd_idx  (in_ctx),
		.rd_live (rd_live),
		.sts     (live_sts),
		.slot    (scan_slot)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ctx   = CTX_W'(context_req);
	// slot numbers past the table are dead by definition
	assign ctx_ok   = (32'(context_req) < 32'(CONTEXTS)) && rd_live;

	assign last_event = (done_q == want_q);

	// ring size for setup: request plus one, at least MIN_RING, at most RING_DEPTH
	always_comb begin
		logic [31:0] cap;
		if (ring_request_q >= 32'(RING_DEPTH)) begin
			cap = 32'(RING_DEPTH);
		end else begin
			cap = ring_request_q + 32'd1;
			if (cap < 32'(MIN_RING)) begin
				cap = 32'(MIN_RING);
			end
			if (cap > 32'(RING_DEPTH)) begin
				cap = 32'(RING_DEPTH);
			end
		end
		setup_size = CNT_W'(cap);
	end

	// push: a full ring drops its oldest event, so the count stays put
	always_comb begin
		push_meta      = meta_rdata;
		push_meta.wp   = advance(meta_rdata.wp, meta_rdata.size);
		if (meta_rdata.count >= meta_rdata.size) begin
			push_meta.rp = advance(meta_rdata.rp, meta_rdata.size);
		end else begin
			push_meta.count = meta_rdata.count + CNT_W'(1);
		end
	end

	// drain length: the smaller of the ask, the fill and the per-command cap
	always_comb begin
		drain_want = max_events_q[DCNT_W-1:0];
		if (max_events_q > ME_W'(mccr_pkg::MAX_RESULTS)) begin
			drain_want = DCNT_W'(mccr_pkg::MAX_RESULTS);
		end
		if (ME_W'(meta_rdata.count) < ME_W'(drain_want)) begin
			drain_want = DCNT_W'(meta_rdata.count);
		end
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		resp_status_d = resp_status_q;
		resp_ctx_d    = resp_ctx_q;
		out_load      = 1'b0;
		live_ctl      = '0;
		live_wr_idx   = in_ctx;
		meta_we       = 1'b0;
		meta_re       = 1'b0;
		meta_waddr    = ctx_q;
		meta_wdata    = push_meta;
		ev_we         = 1'b0;
		ev_waddr      = ev_addr(ctx_q, meta_rdata.wp);
		ev_re         = 1'b0;
		ev_raddr      = ev_addr(ctx_q, rp_q);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					resp_ctx_d    = '0;
					resp_status_d = mccr_pkg::ST_INVALID;
					state_d       = S_RESP;
					unique case (opcode)
						mccr_pkg::OP_SETUP: begin
							if (ring_request != '0) begin
								live_ctl.scan_start = 1'b1;
								state_d             = S_SCAN;
							end
						end
						mccr_pkg::OP_DESTROY: begin
							if (ctx_ok) begin
								live_ctl.clear = 1'b1;
								resp_status_d  = mccr_pkg::ST_OK;
							end
						end
						mccr_pkg::OP_PUSH: begin
							if (ctx_ok) begin
								meta_re = 1'b1;
								state_d = S_META;
							end
						end
						mccr_pkg::OP_DRAIN: begin
							if (ctx_ok && !max_events[ME_W-1]) begin
								meta_re = 1'b1;
								state_d = S_META;
							end
						end
						default: begin
							// cancel and undefined codes answer invalid
						end
					endcase
				end
			end
			S_SCAN: begin
				if (live_sts.done) begin
					state_d = S_RESP;
					if (live_sts.found) begin
						live_ctl.set     = 1'b1;
						live_wr_idx      = scan_slot;
						meta_we          = 1'b1;
						meta_waddr       = scan_slot;
						meta_wdata       = '0;
						meta_wdata.size  = setup_size;
						resp_status_d    = mccr_pkg::ST_OK;
						resp_ctx_d       = REQ_W'(scan_slot);
					end else begin
						resp_status_d = mccr_pkg::ST_NO_CTX;
					end
				end
			end
			S_META: begin
				resp_status_d = mccr_pkg::ST_OK;
				if (op_q == mccr_pkg::OP_PUSH) begin
					meta_we = 1'b1;
					ev_we   = 1'b1;
					state_d = S_RESP;
				end else if (drain_want == '0) begin
					state_d = S_RESP;
				end else begin
					state_d = S_DRD;
				end
			end
			S_DRD: begin
				ev_re   = 1'b1;
				state_d = S_DOUT;
			end
			S_DOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (last_event) begin
						meta_we    = 1'b1;
						meta_wdata = '{size: size_q, rp: rp_q, wp: wp_q, count: cnt_q};
						state_d    = S_IDLE;
					end else begin
						state_d = S_DRD;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: command latch, working copy and output word
	always_ff @(posedge clk) begin
		resp_status_q <= resp_status_d;
		resp_ctx_q    <= resp_ctx_d;
		if (accept) begin
			op_q           <= opcode;
			ctx_q          <= in_ctx;
			ring_request_q <= ring_request;
			max_events_q   <= max_events;
			event_word_q   <= {user_data, request_tag, outcome};
		end
		if (state_q == S_META) begin
			size_q <= meta_rdata.size;
			rp_q   <= meta_rdata.rp;
			wp_q   <= meta_rdata.wp;
			cnt_q  <= meta_rdata.count;
			want_q <= drain_want;
			done_q <= '0;
		end
		if (state_q == S_DRD) begin
			rp_q   <= advance(rp_q, size_q);
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= done_q + DCNT_W'(1);
		end
		if (out_load) begin
			if (state_q == S_DOUT) begin
				status_q         <= mccr_pkg::ST_OK;
				context_out_q    <= '0;
				has_event_q      <= 1'b1;
				event_word_out_q <= ev_rdata;
				drained_count_q  <= done_q;
				last_q           <= last_event;
			end else begin
				status_q         <= resp_status_q;
				context_out_q    <= resp_ctx_q;
				has_event_q      <= 1'b0;
				event_word_out_q <= '0;
				drained_count_q  <= '0;
				last_q           <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign context_out   = context_out_q;
	assign has_event     = has_event_q;
	assign event_data    = event_word_out_q[3*WORD_W-1 -: WORD_W];
	assign event_tag     = event_word_out_q[2*WORD_W-1 -: WORD_W];
	assign event_outcome = event_word_out_q[WORD_W-1:0];
	assign drained_count = drained_count_q;
	assign last          = last_q;

	// a drained event always reports success with a nonzero position
	`MCCR_ASSERT_IMP(a_event_ok, out_valid && has_event, (status == mccr_pkg::ST_OK) && (drained_count != '0) && (context_out == '0), "drained event with bad status or count")

	// only drains produce more than one word per command
	`MCCR_ASSERT_IMP(a_multi_is_drain, out_valid && !last, has_event, "non-final word without an event")

	// one command at a time: the input closes right after a word is taken
	`MCCR_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input accepted while busy")

endmodule

`default_nettype wire

// ===== bench/completion_rings_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the completion ring unit: watches the command and result
// channels, keeps a shadow context table and compares every result word.
// Depends on mccr_pkg.
module completion_rings_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic        [mccr_pkg::OP_W-1:0]    opcode,
	input  wire logic        [mccr_pkg::REQ_W-1:0]   context_req,
	input  wire logic        [mccr_pkg::RREQ_W-1:0]  ring_request,
	input  wire logic signed [mccr_pkg::ME_W-1:0]    max_events,
	input  wire logic        [mccr_pkg::WORD_W-1:0]  user_data,
	input  wire logic        [mccr_pkg::WORD_W-1:0]  request_tag,
	input  wire logic signed [mccr_pkg::WORD_W-1:0]  outcome,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic        [mccr_pkg::ST_W-1:0]    status,
	input  wire logic        [mccr_pkg::REQ_W-1:0]   context_out,
	input  wire logic                                has_event,
	input  wire logic        [mccr_pkg::WORD_W-1:0]  event_data,
	input  wire logic        [mccr_pkg::WORD_W-1:0]  event_tag,
	input  wire logic signed [mccr_pkg::WORD_W-1:0]  event_outcome,
	input  wire logic        [mccr_pkg::DCNT_W-1:0]  drained_count,
	input  wire logic                                last,
	output int                                       mismatches,
	output int                                       outstanding,
	output int                                       events_seen
);

	localparam int SLOTS = mccr_pkg::CONTEXTS_DEF;
	localparam int DEPTH = mccr_pkg::RING_DEPTH_DEF;
	localparam int SHORTEST = mccr_pkg::MIN_RING_DEF;
	localparam int MAX_RESULTS = mccr_pkg::MAX_RESULTS;
	localparam int OP_W = mccr_pkg::OP_W;
	localparam int REQ_W = mccr_pkg::REQ_W;
	localparam int RREQ_W = mccr_pkg::RREQ_W;
	localparam int ME_W = mccr_pkg::ME_W;
	localparam int WORD_W = mccr_pkg::WORD_W;
	localparam int ST_W = mccr_pkg::ST_W;
	localparam int DCNT_W = mccr_pkg::DCNT_W;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [REQ_W-1:0]  slot;
		logic              has;
		logic [WORD_W-1:0] data;
		logic [WORD_W-1:0] tag;
		logic [WORD_W-1:0] result;
		logic [DCNT_W-1:0] count;
		logic              last;
	} completion_t;

	completion_t owed_q[$];

	bit  slot_live [SLOTS];
	int  ring_len  [SLOTS];
	int  head      [SLOTS];
	int  tail      [SLOTS];
	int  fill      [SLOTS];
	logic [WORD_W-1:0] ring_data [SLOTS][DEPTH];
	logic [WORD_W-1:0] ring_tag  [SLOTS][DEPTH];
	logic [WORD_W-1:0] ring_res  [SLOTS][DEPTH];

	int fail_count = 0;
	int drained_total = 0;
	int word_no = 0;

	function automatic int next_pos(input int p, input int len);
		return (p + 1 >= len) ? 0 : p + 1;
	endfunction

	task automatic owe_word(input logic [ST_W-1:0] st, input logic [REQ_W-1:0] slot,
			input logic has, input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] t,
			input logic [WORD_W-1:0] r, input logic [DCNT_W-1:0] cnt, input logic fin);
		owed_q.push_back({st, slot, has, d, t, r, cnt, fin});
	endtask

	task automatic owe_status(input logic [ST_W-1:0] st);
		owe_word(st, '0, 1'b0, '0, '0, '0, '0, 1'b1);
	endtask

	task automatic predict_command(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] c,
			input logic [RREQ_W-1:0] req, input logic signed [ME_W-1:0] ask,
			input logic [WORD_W-1:0] ud, input logic [WORD_W-1:0] tg,
			input logic [WORD_W-1:0] oc);
		int slot;
		int want;
		logic [RREQ_W:0] cap;
		slot = -1;
		case (op)
			mccr_pkg::OP_SETUP: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!slot_live[i]) slot = i;
				cap = {1'b0, req} + (RREQ_W+1)'(1);
				if (req == '0) begin
					owe_status(mccr_pkg::ST_INVALID);
				end else if (slot < 0) begin
					owe_status(mccr_pkg::ST_NO_CTX);
				end else begin
					if (cap < (RREQ_W+1)'(SHORTEST)) cap = (RREQ_W+1)'(SHORTEST);
					if (cap > (RREQ_W+1)'(DEPTH)) cap = (RREQ_W+1)'(DEPTH);
					slot_live[slot] = 1'b1;
					ring_len[slot] = int'(cap);
					head[slot] = 0;
					tail[slot] = 0;
					fill[slot] = 0;
					owe_word(mccr_pkg::ST_OK, slot[REQ_W-1:0], 1'b0, '0, '0, '0, '0, 1'b1);
				end
			end
			mccr_pkg::OP_DESTROY: begin
				if (!slot_live[c]) begin
					owe_status(mccr_pkg::ST_INVALID);
				end else begin
					slot_live[c] = 1'b0;
					owe_status(mccr_pkg::ST_OK);
				end
			end
			mccr_pkg::OP_PUSH: begin
				if (!slot_live[c]) begin
					owe_status(mccr_pkg::ST_INVALID);
				end else begin
					// a full ring loses its oldest event
					if (fill[c] >= ring_len[c]) begin
						head[c] = next_pos(head[c], ring_len[c]);
						fill[c]--;
					end
					ring_data[c][tail[c]] = ud;
					ring_tag[c][tail[c]] = tg;
					ring_res[c][tail[c]] = oc;
					tail[c] = next_pos(tail[c], ring_len[c]);
					fill[c]++;
					owe_status(mccr_pkg::ST_OK);
				end
			end
			mccr_pkg::OP_DRAIN: begin
				if (!slot_live[c] || ask < 0) begin
					owe_status(mccr_pkg::ST_INVALID);
				end else begin
					want = int'(ask);
					if (want > fill[c]) want = fill[c];
					if (want > MAX_RESULTS) want = MAX_RESULTS;
					if (want == 0)
						owe_status(mccr_pkg::ST_OK);
					for (int k = 0; k < want; k++) begin
						owe_word(mccr_pkg::ST_OK, '0, 1'b1, ring_data[c][head[c]],
							ring_tag[c][head[c]], ring_res[c][head[c]], DCNT_W'(k + 1),
							k + 1 == want);
						head[c] = next_pos(head[c], ring_len[c]);
						fill[c]--;
					end
				end
			end
			// cancel and the unused codes
			default: owe_status(mccr_pkg::ST_INVALID);
		endcase
	endtask

	// One line per mismatch, and count it.
	task automatic report_mismatch(input string what);
		$display("%0t ns: result word %0d: %s", $realtime, word_no, what);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
	endtask

	always @(posedge clk) begin : watch
		completion_t seen;
		completion_t owed;
		if (arst_n) begin
			// The result leaving now belongs to an earlier command; check it first.
			if (out_valid && out_ready) begin
				seen = {status, context_out, has_event, event_data, event_tag,
					event_outcome, drained_count, last};
				if (owed_q.size() == 0) begin
					report_mismatch("word arrived with nothing owed");
				end else begin
					owed = owed_q.pop_front();
					compare_field("status", WORD_W'(seen.status), WORD_W'(owed.status));
					compare_field("context_out", WORD_W'(seen.slot), WORD_W'(owed.slot));
					compare_field("has_event", WORD_W'(seen.has), WORD_W'(owed.has));
					compare_field("event_data", seen.data, owed.data);
					compare_field("event_tag", seen.tag, owed.tag);
					compare_field("event_outcome", seen.result, owed.result);
					compare_field("drained_count", WORD_W'(seen.count), WORD_W'(owed.count));
					compare_field("last", WORD_W'(seen.last), WORD_W'(owed.last));
				end
				if (seen.has === 1'b1)
					drained_total++;
				word_no++;
			end
			if (in_valid && in_ready)
				predict_command(opcode, context_req, ring_request, max_events,
					user_data, request_tag, outcome);
		end
		mismatches <= fail_count;
		outstanding <= owed_q.size();
		events_seen <= drained_total;
	end

endmodule

// ===== bench/multi_context_completion_rings_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the completion ring unit testbench: makes commands and result
// back-pressure and gives the verdict. Depends on mccr_pkg, the unit and
// completion_rings_checker.
module multi_context_completion_rings_unit_test;

	// Generous ceiling: the slowest legal run needs a small fraction of this.
	localparam int TIMEOUT_NS = 1_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PCT = 35;
	localparam int MAX_RESULTS = mccr_pkg::MAX_RESULTS;
	localparam int OP_W = mccr_pkg::OP_W;
	localparam int REQ_W = mccr_pkg::REQ_W;
	localparam int RREQ_W = mccr_pkg::RREQ_W;
	localparam int ME_W = mccr_pkg::ME_W;
	localparam int WORD_W = mccr_pkg::WORD_W;
	localparam int ST_W = mccr_pkg::ST_W;
	localparam int DCNT_W = mccr_pkg::DCNT_W;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          opcode = mccr_pkg::OP_CANCEL;
	logic [REQ_W-1:0]         context_req = '0;
	logic [RREQ_W-1:0]        ring_request = '0;
	logic signed [ME_W-1:0]   max_events = '0;
	logic [WORD_W-1:0]        user_data = '0;
	logic [WORD_W-1:0]        request_tag = '0;
	logic signed [WORD_W-1:0] outcome = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ST_W-1:0]          status;
	logic [REQ_W-1:0]         context_out;
	logic                     has_event;
	logic [WORD_W-1:0]        event_data;
	logic [WORD_W-1:0]        event_tag;
	logic signed [WORD_W-1:0] event_outcome;
	logic [DCNT_W-1:0]        drained_count;
	logic                     last;

	int mismatches;
	int outstanding;
	int events_seen;

	// High while both sides run flat out, with no idle cycles at all.
	bit quiet = 1'b0;
	int words_sent = 0;
	int op_count [8];

	multi_context_completion_rings_unit i_dut (
		.clk, .arst_n,
		.in_valid, .in_ready,
		.opcode, .context_req, .ring_request, .max_events,
		.user_data, .request_tag, .outcome,
		.out_valid, .out_ready,
		.status, .context_out, .has_event, .event_data, .event_tag,
		.event_outcome, .drained_count, .last
	);

	completion_rings_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .context_req(context_req), .ring_request(ring_request),
		.max_events(max_events), .user_data(user_data), .request_tag(request_tag),
		.outcome(outcome),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .context_out(context_out), .has_event(has_event),
		.event_data(event_data), .event_tag(event_tag), .event_outcome(event_outcome),
		.drained_count(drained_count), .last(last),
		.mismatches(mismatches), .outstanding(outstanding), .events_seen(events_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random, except during the quiet stretch.
	always @(posedge clk) begin
		if (quiet)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic logic [WORD_W-1:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Pick a context: mostly the low slots, where setup keeps landing, so
	// that pushes and drains find live rings; now and then any slot at all.
	function automatic logic [REQ_W-1:0] pick_slot();
		if ($urandom_range(99) < 85)
			return REQ_W'($urandom_range(0, 7));
		return REQ_W'($urandom_range(0, 63));
	endfunction

	// Present one command word and hold it until the unit takes it. Idle
	// cycles go in front with valid low; valid is never dropped under a word.
	task automatic send_command(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] slot,
			input logic [RREQ_W-1:0] req, input logic signed [ME_W-1:0] ask,
			input logic [WORD_W-1:0] ud, input logic [WORD_W-1:0] tg,
			input logic signed [WORD_W-1:0] oc);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		context_req <= slot;
		ring_request <= req;
		max_events <= ask;
		user_data <= ud;
		request_tag <= tg;
		outcome <= oc;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		op_count[op]++;
	endtask

	// One command from the general mix: mostly pushes and drains on live
	// rings with random content, a few setups and destroys to churn the
	// table, and some cancels, unused codes and bad counts as noise.
	task automatic mixed_command();
		int pick;
		logic [RREQ_W-1:0] req;
		logic signed [ME_W-1:0] ask;
		pick = $urandom_range(99);
		case ($urandom_range(19)) inside
			0:       req = '0;
			[1:3]:   req = $urandom;
			default: req = RREQ_W'($urandom_range(1, 20));
		endcase
		case ($urandom_range(19)) inside
			0:       ask = ME_W'(MAX_RESULTS);
			[1:3]:   ask = ME_W'($urandom);
			default: ask = ME_W'($urandom_range(0, 20));
		endcase
		if (pick < 8)
			send_command(mccr_pkg::OP_SETUP, REQ_W'($urandom), req, ask,
				rnd64(), rnd64(), rnd64());
		else if (pick < 13)
			send_command(mccr_pkg::OP_DESTROY, pick_slot(), req, ask,
				rnd64(), rnd64(), rnd64());
		else if (pick < 58)
			send_command(mccr_pkg::OP_PUSH, pick_slot(), req, ask,
				rnd64(), rnd64(), rnd64());
		else if (pick < 88)
			send_command(mccr_pkg::OP_DRAIN, pick_slot(), req, ask,
				rnd64(), rnd64(), rnd64());
		else if (pick < 94)
			send_command(mccr_pkg::OP_CANCEL, pick_slot(), req, ask,
				rnd64(), rnd64(), rnd64());
		else
			send_command(OP_W'($urandom_range(5, 7)), REQ_W'($urandom), req, ask,
				rnd64(), rnd64(), rnd64());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing is live yet: every command that names a context bounces,
		// and so do cancel and the unused codes.
		send_command(mccr_pkg::OP_DRAIN, 6'd0, '0, 16'sd1, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_DESTROY, 6'd63, '0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_PUSH, 6'd5, '0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_CANCEL, 6'd0, '1, 16'sd3, rnd64(), rnd64(), rnd64());
		for (int k = 5; k < 8; k++)
			send_command(OP_W'(k), 6'd0, '0, 16'sd0, rnd64(), rnd64(), rnd64());

		// Setup: a zero request is refused, one asks for the shortest ring,
		// the largest request saturates at the full depth.
		send_command(mccr_pkg::OP_SETUP, 6'd0, 32'd0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_SETUP, 6'd0, 32'd1, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_SETUP, 6'd63, 32'hFFFF_FFFF, 16'sd0,
			rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_SETUP, 6'd0, 32'd15, 16'sd0, rnd64(), rnd64(), rnd64());

		// Empty drains, asked for nothing and for everything; negative counts.
		send_command(mccr_pkg::OP_DRAIN, 6'd0, '0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_DRAIN, 6'd1, '0, 16'sh7FFF, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_DRAIN, 6'd0, '0, 16'sh8000, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_DRAIN, 6'd0, '0, -16'sd1, rnd64(), rnd64(), rnd64());

		// Payload extremes through one ring, then read back oldest first.
		send_command(mccr_pkg::OP_PUSH, 6'd0, '0, 16'sd0, '1, '1, 64'sh8000_0000_0000_0000);
		send_command(mccr_pkg::OP_PUSH, 6'd0, '0, 16'sd0, '0, '0, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_command(mccr_pkg::OP_PUSH, 6'd0, '0, 16'sd0, rnd64(), rnd64(), -64'sd1);
		send_command(mccr_pkg::OP_DRAIN, 6'd0, '0, 16'sh7FFF, rnd64(), rnd64(), rnd64());

		// Destroy, use the dead slot, then see setup take it back.
		send_command(mccr_pkg::OP_DESTROY, 6'd0, '0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_PUSH, 6'd0, '0, 16'sd0, rnd64(), rnd64(), rnd64());
		send_command(mccr_pkg::OP_SETUP, 6'd0, 32'd7, 16'sd0, rnd64(), rnd64(), rnd64());

		repeat (160)
			mixed_command();

		// Hold off until the unit has returned every word owed.
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);

		// Fill the table to the last slot so later setups find none free,
		// then punch holes in the upper part of it.
		repeat (68)
			send_command(mccr_pkg::OP_SETUP, REQ_W'($urandom), RREQ_W'($urandom_range(1, 40)),
				ME_W'($urandom), rnd64(), rnd64(), rnd64());
		repeat (45)
			send_command(mccr_pkg::OP_DESTROY, REQ_W'($urandom_range(8, 63)), $urandom,
				ME_W'($urandom), rnd64(), rnd64(), rnd64());

		// Run flat out on both sides for a while, then back to random idling.
		quiet <= 1'b1;
		repeat (90)
			mixed_command();
		quiet <= 1'b0;
		repeat (90)
			mixed_command();

		// Drop valid and wait for the last results to come back.
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d setup, %0d destroy, %0d push, %0d drain, %0d other.",
			words_sent, op_count[mccr_pkg::OP_SETUP], op_count[mccr_pkg::OP_DESTROY],
			op_count[mccr_pkg::OP_PUSH], op_count[mccr_pkg::OP_DRAIN],
			op_count[mccr_pkg::OP_CANCEL] + op_count[5] + op_count[6] + op_count[7]);
		$display("Drains returned %0d events; %0d result mismatches.", events_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d result words still owed.", outstanding);
		$display("FAIL");
		$finish;
	end

endmodule
